// ===== rtl/jts_pkg.sv =====
// Shared types, token codes and character helpers of the JSON token scanner.
package jts_pkg;

    // Result kinds
    localparam logic [3:0] K_TEXT    = 4'd0;
    localparam logic [3:0] K_END     = 4'd1;
    localparam logic [3:0] K_LBRACE  = 4'd2;
    localparam logic [3:0] K_RBRACE  = 4'd3;
    localparam logic [3:0] K_LBRACK  = 4'd4;
    localparam logic [3:0] K_RBRACK  = 4'd5;
    localparam logic [3:0] K_COMMA   = 4'd6;
    localparam logic [3:0] K_COLON   = 4'd7;
    localparam logic [3:0] K_STRING  = 4'd8;
    localparam logic [3:0] K_NULL    = 4'd9;
    localparam logic [3:0] K_BOOL    = 4'd10;
    localparam logic [3:0] K_REAL    = 4'd11;
    localparam logic [3:0] K_SINT    = 4'd12;
    localparam logic [3:0] K_UINT    = 4'd13;
    localparam logic [3:0] K_UNKNOWN = 4'd14;
    localparam logic [3:0] K_DISCARD = 4'd15;

    // Characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_ESC    = 8'h1b;

    localparam logic [2:0] LEN_MAX = 3'd7;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_STRING  = 4'b0010,
        MODE_ESCAPE  = 4'b0100,
        MODE_COMMENT = 4'b1000
    } mode_t;

    typedef enum logic [9:0] {
        N_START = 10'b0000000001,
        N_SIGN  = 10'b0000000010,
        N_UDIG  = 10'b0000000100,
        N_SDIG  = 10'b0000001000,
        N_DOT   = 10'b0000010000,
        N_FRAC  = 10'b0000100000,
        N_EXP   = 10'b0001000000,
        N_ESIGN = 10'b0010000000,
        N_EDIG  = 10'b0100000000,
        N_DEAD  = 10'b1000000000
    } num_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] text;
        logic       unterm;
    } res_t;

    // One queue entry: the results of one input beat
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    // Keyword candidate idx (0 null, 1 true, 2 false) still matches at position pos
    function automatic logic kw_hit(input logic [1:0] idx, input logic [2:0] pos,
                                    input logic [7:0] c);
        logic [7:0] want;
        logic       ok;
        begin
            want = 8'h00;
            ok   = 1'b1;
            case ({idx, pos})
                {2'd0, 3'd0}: want = 8'h6e;
                {2'd0, 3'd1}: want = 8'h75;
                {2'd0, 3'd2}: want = 8'h6c;
                {2'd0, 3'd3}: want = 8'h6c;
                {2'd1, 3'd0}: want = 8'h74;
                {2'd1, 3'd1}: want = 8'h72;
                {2'd1, 3'd2}: want = 8'h75;
                {2'd1, 3'd3}: want = 8'h65;
                {2'd2, 3'd0}: want = 8'h66;
                {2'd2, 3'd1}: want = 8'h61;
                {2'd2, 3'd2}: want = 8'h6c;
                {2'd2, 3'd3}: want = 8'h73;
                {2'd2, 3'd4}: want = 8'h65;
                default:      ok = 1'b0;
            endcase
            return ok && (c == want);
        end
    endfunction

    function automatic logic [7:0] translate(input logic [7:0] c);
        logic [7:0] r;
        begin
            case (c)
                8'h61:   r = 8'h07;
                8'h62:   r = 8'h08;
                8'h74:   r = 8'h09;
                8'h6e:   r = 8'h0a;
                8'h72:   r = 8'h0d;
                8'h76:   r = 8'h0b;
                8'h66:   r = 8'h0c;
                8'h65:   r = CH_ESC;
                default: r = c;
            endcase
            return r;
        end
    endfunction

    function automatic logic [3:0] word_class(input logic [2:0] match, input logic [2:0] len,
                                              input num_t ns);
        logic [3:0] k;
        begin
            if (match[0] && len == 3'd4) begin
                k = K_NULL;
            end else if ((match[1] && len == 3'd4) || (match[2] && len == 3'd5)) begin
                k = K_BOOL;
            end else begin
                case (ns)
                    N_UDIG:                  k = K_UINT;
                    N_SDIG:                  k = K_SINT;
                    N_DOT, N_FRAC, N_EDIG:   k = K_REAL;
                    default:                 k = K_UNKNOWN;
                endcase
            end
            return k;
        end
    endfunction

    function automatic num_t next_number(input num_t s, input logic [7:0] c);
        logic dig;
        logic sgn;
        logic e;
        num_t n;
        begin
            dig = (c >= CH_ZERO) && (c <= CH_NINE);
            sgn = (c == CH_PLUS) || (c == CH_MINUS);
            e   = (c == CH_UPPER_E) || (c == 8'h65);
            case (s)
                N_START:       n = sgn ? N_SIGN : (dig ? N_UDIG : N_DEAD);
                N_SIGN:        n = dig ? N_SDIG : N_DEAD;
                N_UDIG, N_SDIG:
                    n = dig ? s : ((c == CH_DOT) ? N_DOT : (e ? N_EXP : N_DEAD));
                N_DOT, N_FRAC: n = dig ? N_FRAC : (e ? N_EXP : N_DEAD);
                N_EXP:         n = sgn ? N_ESIGN : (dig ? N_EDIG : N_DEAD);
                N_ESIGN, N_EDIG: n = dig ? N_EDIG : N_DEAD;
                default:       n = N_DEAD;
            endcase
            return n;
        end
    endfunction

endpackage

// ===== rtl/jts_front.sv =====
// Front end: accepts input beats, tracks scanner state, builds result entries.
module jts_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tuser,   // [0] op (1 = end of input)
    input  logic                q_full,
    output logic                q_push,
    output jts_pkg::entry_t     q_entry
);
    import jts_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [7:0] prev_reg, prev_next;
    logic       word_reg, word_next;
    num_t       num_reg, num_next;
    logic [2:0] match_reg, match_next;
    logic [2:0] len_reg, len_next;

    logic       accept;
    logic [7:0] c;
    logic       is_space, is_quote, is_comment;
    logic [3:0] delim;
    logic       pre_v, main_v;
    res_t       pre_r, main_r;
    logic [3:0] cls;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign cls      = word_class(match_reg, len_reg, num_reg);

    always_comb begin
        is_space = (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) ||
                   (c == CH_VT) || (c == CH_FF);
        is_quote = (c == CH_QUOTE);
        is_comment = (c == CH_HASH) || ((c == CH_SLASH) && (prev_reg == CH_SLASH));
        case (c)
            CH_LBRACE: delim = K_LBRACE;
            CH_RBRACE: delim = K_RBRACE;
            CH_LBRACK: delim = K_LBRACK;
            CH_RBRACK: delim = K_RBRACK;
            CH_COMMA:  delim = K_COMMA;
            CH_COLON:  delim = K_COLON;
            default:   delim = K_TEXT;
        endcase
    end

    always_comb begin
        mode_next  = mode_reg;
        prev_next  = prev_reg;
        word_next  = word_reg;
        num_next   = num_reg;
        match_next = match_reg;
        len_next   = len_reg;
        pre_v      = 1'b0;
        pre_r      = '{kind: cls, text: 8'h00, unterm: 1'b0};
        main_v     = 1'b0;
        main_r     = '{kind: K_TEXT, text: 8'h00, unterm: 1'b0};

        if (s_tuser) begin
            pre_v  = (mode_reg == MODE_NORMAL) && word_reg;
            main_v = 1'b1;
            main_r = '{kind: K_END, text: 8'h00,
                       unterm: (mode_reg == MODE_STRING) || (mode_reg == MODE_ESCAPE)};
            mode_next  = MODE_NORMAL;
            prev_next  = 8'h00;
            word_next  = 1'b0;
            num_next   = N_START;
            match_next = 3'b111;
            len_next   = 3'd0;
        end else begin
            case (mode_reg)
                MODE_COMMENT: begin
                    if ((c == CH_LF) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR)) begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_ESCAPE: begin
                    main_v    = 1'b1;
                    main_r    = '{kind: K_TEXT, text: translate(c), unterm: 1'b0};
                    mode_next = MODE_STRING;
                end
                MODE_STRING: begin
                    if (c == CH_BSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end else if (is_quote) begin
                        main_v    = 1'b1;
                        main_r    = '{kind: K_STRING, text: 8'h00, unterm: 1'b0};
                        mode_next = MODE_NORMAL;
                        prev_next = 8'h00;
                    end else begin
                        main_v = 1'b1;
                        main_r = '{kind: K_TEXT, text: c, unterm: 1'b0};
                    end
                end
                default: begin
                    // a token byte ends the pending word first
                    if ((is_space || is_quote || delim != K_TEXT) && word_reg) begin
                        pre_v      = 1'b1;
                        word_next  = 1'b0;
                        num_next   = N_START;
                        match_next = 3'b111;
                        len_next   = 3'd0;
                        prev_next  = 8'h00;
                    end
                    if (is_space) begin
                        prev_next = c;
                    end else if (is_quote) begin
                        mode_next = MODE_STRING;
                        prev_next = 8'h00;
                    end else if (delim != K_TEXT) begin
                        main_v    = 1'b1;
                        main_r    = '{kind: delim, text: 8'h00, unterm: 1'b0};
                        prev_next = 8'h00;
                    end else if (is_comment) begin
                        // drop the pending word
                        main_v     = word_reg;
                        main_r     = '{kind: K_DISCARD, text: 8'h00, unterm: 1'b0};
                        word_next  = 1'b0;
                        num_next   = N_START;
                        match_next = 3'b111;
                        len_next   = 3'd0;
                        mode_next  = MODE_COMMENT;
                        prev_next  = c;
                    end else begin
                        word_next  = 1'b1;
                        match_next = match_reg & {kw_hit(2'd2, len_reg, c),
                                                  kw_hit(2'd1, len_reg, c),
                                                  kw_hit(2'd0, len_reg, c)};
                        len_next   = (len_reg == LEN_MAX) ? LEN_MAX : len_reg + 3'd1;
                        num_next   = next_number(num_reg, c);
                        main_v     = 1'b1;
                        main_r     = '{kind: K_TEXT, text: c, unterm: 1'b0};
                        prev_next  = c;
                    end
                end
            endcase
        end
    end

    assign q_push     = accept && (pre_v || main_v);
    assign q_entry.two = pre_v && main_v;
    assign q_entry.r0  = pre_v ? pre_r : main_r;
    assign q_entry.r1  = main_r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            prev_reg  <= 8'h00;
            word_reg  <= 1'b0;
            num_reg   <= N_START;
            match_reg <= 3'b111;
            len_reg   <= 3'd0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            prev_reg  <= prev_next;
            word_reg  <= word_next;
            num_reg   <= num_next;
            match_reg <= match_next;
            len_reg   <= len_next;
        end
    end

    // a word never stays open outside normal mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_NORMAL) |-> !word_reg)
        else $error("word open outside normal mode");

    // an idle word has fresh classifier state
    assert property (@(posedge aclk) disable iff (!aresetn)
        !word_reg |-> (len_reg == 3'd0 && num_reg == N_START && match_reg == 3'b111))
        else $error("classifier not cleared");

endmodule

// ===== rtl/jts_fifo.sv =====
// Short queue of result entries between front and back.
module jts_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  jts_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output logic             avail,
    output jts_pkg::entry_t  head
);
    import jts_pkg::*;

    entry_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_reg;
    logic [FIFO_AW-1:0]     rd_reg;
    logic [FIFO_AW:0]       cnt_reg;
    logic                   do_push, do_pop;

    assign full    = (cnt_reg == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign avail   = (cnt_reg != '0);
    assign head    = mem[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= wr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_reg <= rd_reg + FIFO_AW'(1);
            end
            cnt_reg <= cnt_reg + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/jts_back.sv =====
// Back end: unpacks queue entries into result beats on the output register.
module jts_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_avail,
    input  jts_pkg::entry_t  q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [7:0] text_byte, [8] unterminated, [15:9] zero
    output logic [3:0]       m_tuser,   // [3:0] kind
    output logic             m_tlast
);
    import jts_pkg::*;

    logic   has_reg;
    logic   sel_reg;
    entry_t ent_reg;
    res_t   cur;
    logic   beat_done, ent_done, take;

    assign cur       = sel_reg ? ent_reg.r1 : ent_reg.r0;
    assign m_tvalid  = has_reg;
    assign m_tuser   = cur.kind;
    assign m_tdata   = {7'b0, cur.unterm, cur.text};
    assign m_tlast   = sel_reg || !ent_reg.two;
    assign beat_done = has_reg && m_tready;
    assign ent_done  = beat_done && m_tlast;
    assign take      = !has_reg || ent_done;
    assign q_pop     = take && q_avail;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_reg <= 1'b0;
            sel_reg <= 1'b0;
        end else if (take) begin
            has_reg <= q_avail;
            sel_reg <= 1'b0;
        end else if (beat_done) begin
            // advance to the second beat of the entry
            sel_reg <= 1'b1;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> (has_reg && ent_reg.two))
        else $error("second beat without a two-beat entry");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (has_reg && !m_tready) |=> (has_reg && $stable(sel_reg)))
        else $error("beat lost while stalled");

endmodule

// ===== rtl/json_token_scanner.sv =====
// Top level of the JSON token scanner: front end, entry queue and back end.
//
// Takes one input beat per cycle while s_tready is high (a text byte, or end
// of input when s_tuser is set) and produces zero, one or two result beats per
// input beat, each tagged with its kind on m_tuser and with m_tlast on the last
// result of that input. The front end classifies each byte combinationally and
// writes its results as one entry into a four-entry queue; s_tready drops only
// when that queue is full. The back end emits one result beat per cycle from its
// output register while m_tready is high, so the sustained rate is one input
// byte per cycle as long as inputs giving two results (a delimiter ending a word,
// or end of input after a word) are spread out; each of those takes an extra
// output beat. A result passes from the queue into the output register before it
// is valid on the output, and waits in the queue while m_tready holds it back.
module json_token_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] op (1 = end of input)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] text_byte, [8] unterminated, [15:9] zero
    output logic [3:0]  m_tuser,    // [3:0] kind
    output logic        m_tlast
);
    import jts_pkg::*;

    logic   q_push, q_full, q_pop, q_avail;
    entry_t q_entry, q_head;

    jts_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    jts_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .avail      (q_avail),
        .head       (q_head)
    );

    jts_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_avail  (q_avail),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sim/tb_json_token_scanner.sv =====
// Self-checking testbench of the JSON token scanner: token streams scored against a predictor.
`timescale 1ns / 1ps

module tb_json_token_scanner;
    import jts_pkg::*;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int RANDOM_BEATS = 700;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 150;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] text;
        logic       unterm;
        logic       last;
    } token_t;

    class token_scoreboard;
        mode_t      mode;
        logic [7:0] prev_byte;
        logic       in_word;
        num_t       num_st;
        logic [2:0] kw_live;
        logic [2:0] word_len;
        string      kw_word[3];
        token_t     pending_q[$];
        int         errors;
        int         n_inputs;
        int         n_ends;
        int         n_checked;
        int         kind_seen[16];
        int         n_unterm;

        function new();
            kw_word[0] = "null";
            kw_word[1] = "true";
            kw_word[2] = "false";
            errors = 0;
            n_inputs = 0;
            n_ends = 0;
            n_checked = 0;
            n_unterm = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
            restart();
        endfunction

        function void clear_word();
            in_word  = 1'b0;
            num_st   = N_START;
            kw_live  = 3'b111;
            word_len = 3'd0;
        endfunction

        function void restart();
            mode      = MODE_NORMAL;
            prev_byte = 8'h00;
            clear_word();
        endfunction

        function token_t make_token(logic [3:0] k, logic [7:0] t, logic u);
            token_t r;
            r.kind   = k;
            r.text   = t;
            r.unterm = u;
            r.last   = 1'b0;
            return r;
        endfunction

        function logic [3:0] word_kind();
            logic [3:0] k;
            case (num_st)
                N_UDIG:                k = K_UINT;
                N_SDIG:                k = K_SINT;
                N_DOT, N_FRAC, N_EDIG: k = K_REAL;
                default:               k = K_UNKNOWN;
            endcase
            // keywords win over numbers, null over bool
            if (kw_live[2] && word_len == 3'd5) k = K_BOOL;
            if (kw_live[1] && word_len == 3'd4) k = K_BOOL;
            if (kw_live[0] && word_len == 3'd4) k = K_NULL;
            return k;
        endfunction

        function logic [7:0] unescape(logic [7:0] c);
            logic [7:0] r;
            case (c)
                "a":     r = 8'h07;
                "b":     r = 8'h08;
                "t":     r = CH_TAB;
                "n":     r = CH_LF;
                "r":     r = CH_CR;
                "v":     r = CH_VT;
                "f":     r = CH_FF;
                "e":     r = CH_ESC;
                default: r = c;
            endcase
            return r;
        endfunction

        function void feed_word_byte(logic [7:0] c);
            logic dig;
            logic sgn;
            logic is_e;
            dig  = (c >= CH_ZERO) && (c <= CH_NINE);
            sgn  = (c == CH_PLUS) || (c == CH_MINUS);
            is_e = (c == CH_UPPER_E) || (c == "e");
            in_word = 1'b1;
            for (int i = 0; i < 3; i++)
                if (word_len >= kw_word[i].len() || kw_word[i][word_len] != c)
                    kw_live[i] = 1'b0;
            if (word_len < LEN_MAX) word_len = word_len + 3'd1;
            case (num_st)
                N_START:         num_st = sgn ? N_SIGN : (dig ? N_UDIG : N_DEAD);
                N_SIGN:          num_st = dig ? N_SDIG : N_DEAD;
                N_UDIG, N_SDIG:  num_st = dig ? num_st :
                                          (c == CH_DOT) ? N_DOT : (is_e ? N_EXP : N_DEAD);
                N_DOT, N_FRAC:   num_st = dig ? N_FRAC : (is_e ? N_EXP : N_DEAD);
                N_EXP:           num_st = sgn ? N_ESIGN : (dig ? N_EDIG : N_DEAD);
                N_ESIGN, N_EDIG: num_st = dig ? N_EDIG : N_DEAD;
                default:         num_st = N_DEAD;
            endcase
        endfunction

        function void note_input(logic op, logic [7:0] c);
            token_t     out_q[$];
            logic [3:0] delim;
            logic       is_space;
            logic       is_quote;
            logic       is_comment;
            logic       line_end;
            n_inputs++;
            line_end = (c == CH_LF) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
            if (op == OP_END) begin
                n_ends++;
                if (mode == MODE_NORMAL && in_word)
                    out_q.insert(out_q.size(), make_token(word_kind(), 8'h00, 1'b0));
                out_q.insert(out_q.size(),
                             make_token(K_END, 8'h00,
                                        mode == MODE_STRING || mode == MODE_ESCAPE));
                restart();
            end else if (mode == MODE_COMMENT) begin
                if (line_end) mode = MODE_NORMAL;
            end else if (mode == MODE_ESCAPE) begin
                out_q.insert(out_q.size(), make_token(K_TEXT, unescape(c), 1'b0));
                mode = MODE_STRING;
            end else if (mode == MODE_STRING) begin
                if (c == CH_BSLASH) begin
                    mode = MODE_ESCAPE;
                end else if (c == CH_QUOTE) begin
                    out_q.insert(out_q.size(), make_token(K_STRING, 8'h00, 1'b0));
                    mode = MODE_NORMAL;
                    prev_byte = 8'h00;
                end else begin
                    out_q.insert(out_q.size(), make_token(K_TEXT, c, 1'b0));
                end
            end else begin
                is_space   = line_end || (c == CH_SPACE) || (c == CH_TAB);
                is_quote   = (c == CH_QUOTE);
                is_comment = (c == CH_HASH) || (c == CH_SLASH && prev_byte == CH_SLASH);
                case (c)
                    CH_LBRACE: delim = K_LBRACE;
                    CH_RBRACE: delim = K_RBRACE;
                    CH_LBRACK: delim = K_LBRACK;
                    CH_RBRACK: delim = K_RBRACK;
                    CH_COMMA:  delim = K_COMMA;
                    CH_COLON:  delim = K_COLON;
                    default:   delim = K_TEXT;
                endcase
                // a token byte closes the pending word first
                if ((is_space || is_quote || delim != K_TEXT) && in_word) begin
                    out_q.insert(out_q.size(), make_token(word_kind(), 8'h00, 1'b0));
                    clear_word();
                    prev_byte = 8'h00;
                end
                if (is_space) begin
                    prev_byte = c;
                end else if (is_quote) begin
                    mode = MODE_STRING;
                    prev_byte = 8'h00;
                end else if (delim != K_TEXT) begin
                    out_q.insert(out_q.size(), make_token(delim, 8'h00, 1'b0));
                    prev_byte = 8'h00;
                end else if (is_comment) begin
                    if (in_word)
                        out_q.insert(out_q.size(), make_token(K_DISCARD, 8'h00, 1'b0));
                    clear_word();
                    mode = MODE_COMMENT;
                    prev_byte = c;
                end else begin
                    feed_word_byte(c);
                    out_q.insert(out_q.size(), make_token(K_TEXT, c, 1'b0));
                    prev_byte = c;
                end
            end
            if (out_q.size() > 0) out_q[out_q.size() - 1].last = 1'b1;
            foreach (out_q[i]) pending_q.insert(pending_q.size(), out_q[i]);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
        endfunction

        function void check_result(logic [3:0] kind, logic [7:0] text, logic unterm,
                                   logic last);
            token_t want;
            n_checked++;
            kind_seen[kind]++;
            if (unterm) n_unterm++;
            if (pending_q.size() == 0) begin
                flag($sformatf("result beat %0d with nothing expected: kind %0d text %02h",
                               n_checked, kind, text));
                return;
            end
            want = pending_q.pop_front();
            if (want.kind !== kind || want.text !== text || want.unterm !== unterm ||
                want.last !== last)
                flag($sformatf({"result beat %0d: expected kind %0d text %02h unterm %0d",
                                " last %0d, got kind %0d text %02h unterm %0d last %0d"},
                               n_checked, want.kind, want.text, want.unterm, want.last,
                               kind, text, unterm, last));
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = OP_BYTE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    token_scoreboard sb = new();
    int  idle_pct = 20;
    int  n_beats = 0;
    int  cycle_count = 0;
    bit  hold_request = 1'b0;
    bit  hold_done = 1'b0;

    json_token_scanner uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_beat(logic op, logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, b);
        n_beats++;
    endtask

    task automatic put_byte(logic [7:0] b);
        send_beat(OP_BYTE, b);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic emit_string();
        string      esc_set;
        int         pick;
        logic [7:0] b;
        esc_set = "abtnrvfe\"\\qx0";
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                b = 8'($urandom_range(32, 126));
                if (b == CH_QUOTE || b == CH_BSLASH) b = "_";
                put_byte(b);
            end else if (pick < 80) begin
                put_byte(CH_BSLASH);
                put_byte(esc_set[$urandom_range(0, esc_set.len() - 1)]);
            end else if (pick < 88) begin
                put_byte(CH_BSLASH);
                put_byte(8'($urandom_range(0, 255)));
            end else begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_QUOTE) b = 8'h80;
                put_byte(b);
            end
        end
        // leave some strings open
        if ($urandom_range(9) != 0) put_byte(CH_QUOTE);
    endtask

    task automatic emit_digits(int lo, int hi);
        repeat ($urandom_range(lo, hi)) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic emit_exponent();
        put_byte($urandom_range(1) ? CH_UPPER_E : "e");
        if ($urandom_range(1)) put_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
        emit_digits($urandom_range(9) == 0 ? 0 : 1, 2);
    endtask

    task automatic emit_number();
        if ($urandom_range(2) == 0) put_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
        emit_digits($urandom_range(7) == 0 ? 0 : 1, 3);
        case ($urandom_range(4))
            1: begin
                put_byte(CH_DOT);
                emit_digits(0, 2);
            end
            2: emit_exponent();
            3: begin
                put_byte(CH_DOT);
                emit_digits(0, 2);
                emit_exponent();
            end
            4: put_byte($urandom_range(1) ? CH_DOT : "x");
            default: ;
        endcase
    endtask

    task automatic emit_keyword();
        string kw_pool[8];
        kw_pool = '{"null", "true", "false", "nul", "truex", "fals", "False", "nulll"};
        put_text(kw_pool[$urandom_range(0, 7)]);
    endtask

    task automatic emit_word();
        repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(33, 126)));
    endtask

    task automatic emit_space();
        logic [7:0] ws[6];
        ws = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
        put_byte(ws[$urandom_range(0, 5)]);
    endtask

    task automatic emit_delim();
        logic [7:0] dl[6];
        dl = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON};
        put_byte(dl[$urandom_range(0, 5)]);
    endtask

    task automatic emit_comment();
        logic [7:0] stop[4];
        logic [7:0] b;
        stop = '{CH_LF, CH_VT, CH_FF, CH_CR};
        if ($urandom_range(1)) put_byte(CH_HASH);
        else put_text("//");
        repeat ($urandom_range(0, 5)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_LF || b == CH_VT || b == CH_FF || b == CH_CR) b = "x";
            put_byte(b);
        end
        if ($urandom_range(9) != 0) put_byte(stop[$urandom_range(0, 3)]);
    endtask

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        int held;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[7:0], m_tdata[8], m_tlast);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending_q.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int  pick;
        int  goal;
        bit  paused;
        paused = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: escapes, keyword, real, double slash, hash comment, extreme bytes
        put_text("{\"\\q\\n\":null");
        put_text(" -1e5]");
        put_text("ab//x\n");
        put_text("#\n");
        put_byte(8'hff);
        put_byte(8'h00);
        send_beat(OP_END, 8'hff);
        put_byte(CH_QUOTE);
        send_beat(OP_END, 8'h00);

        goal = n_beats + RANDOM_BEATS;
        while (n_beats < goal) begin
            if (!hold_done && n_beats >= goal - 450) begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            if (!paused && n_beats >= goal - 250) begin
                wait_results_drained();
                paused = 1'b1;
            end
            // long stretch with no idling on either side
            idle_pct = (n_beats >= goal - 200 && n_beats < goal - 60) ? 0 : 20;

            pick = $urandom_range(99);
            if (pick < 55) begin
                if (pick < 20) emit_string();
                else if (pick < 35) emit_number();
                else if (pick < 45) emit_keyword();
                else emit_word();
                pick = $urandom_range(99);
                if (pick < 50) emit_space();
                else if (pick < 85) emit_delim();
            end else if (pick < 68) begin
                emit_delim();
            end else if (pick < 74) begin
                emit_space();
            end else if (pick < 84) begin
                emit_comment();
            end else if (pick < 92) begin
                put_byte(8'($urandom_range(0, 255)));
            end else if (pick < 96) begin
                // word cut short by a comment start
                emit_word();
                if ($urandom_range(1)) put_byte(CH_HASH);
                else put_text("//");
                put_byte(CH_LF);
            end else begin
                send_beat(OP_END, 8'($urandom_range(0, 255)));
            end
        end
        send_beat(OP_END, 8'h00);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d input beats (%0d end marks), compared %0d result beats.",
                 sb.n_inputs, sb.n_ends, sb.n_checked);
        $display({"Seen: %0d strings, %0d null, %0d bool, %0d real, %0d sint, %0d uint,",
                  " %0d unknown, %0d discarded, %0d unterminated ends."},
                 sb.kind_seen[K_STRING], sb.kind_seen[K_NULL], sb.kind_seen[K_BOOL],
                 sb.kind_seen[K_REAL], sb.kind_seen[K_SINT], sb.kind_seen[K_UINT],
                 sb.kind_seen[K_UNKNOWN], sb.kind_seen[K_DISCARD], sb.n_unterm);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     sb.errors, sb.pending_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/jts_pkg.sv
rtl/jts_front.sv
rtl/jts_fifo.sv
rtl/jts_back.sv
rtl/json_token_scanner.sv
sim/tb_json_token_scanner.sv
